[rtl/ecal_pkg.sv]
// Package for the epoch-seconds-to-calendar block: widths, calendar
// constants, sequencer states, month-length helpers and small mod-7 helpers.
// No dependencies.
package ecal_pkg;

  localparam int unsigned REM_W = 32;

  localparam logic [REM_W-1:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [REM_W-1:0] SECS_PER_MINUTE  = 32'd60;
  localparam logic [REM_W-1:0] YEAR_COMMON_SECS = 32'd31536000;
  localparam logic [REM_W-1:0] YEAR_LEAP_SECS   = 32'd31622400;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;

  typedef struct packed {
    logic             ge;
    logic [REM_W-1:0] diff;
  } alu_res_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_YEAR  = 7'b0000010,
    ST_MONTH = 7'b0000100,
    ST_DAY   = 7'b0001000,
    ST_HOUR  = 7'b0010000,
    ST_MIN   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  // Month length in days, 28..31.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    begin
      case (month)
        4'd2:                      d = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
        default:                   d = 5'd31;
      endcase
      return d;
    end
  endfunction

  // Month length in seconds.
  function automatic logic [REM_W-1:0] month_secs(input logic [3:0] month, input logic leap);
    logic [REM_W-1:0] s;
    begin
      case (month_days(month, leap))
        5'd28:   s = 32'd2419200;
        5'd29:   s = 32'd2505600;
        5'd30:   s = 32'd2592000;
        default: s = 32'd2678400;
      endcase
      return s;
    end
  endfunction

  // Reduce a 5-bit value modulo 7.
  function automatic logic [2:0] mod7_5(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v >= 5'd28)      r = v - 5'd28;
      else if (v >= 5'd21) r = v - 5'd21;
      else if (v >= 5'd14) r = v - 5'd14;
      else if (v >= 5'd7)  r = v - 5'd7;
      else                 r = v;
      return r[2:0];
    end
  endfunction

  // Sum of two values below 7, modulo 7.
  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) s = s - 4'd7;
      return s[2:0];
    end
  endfunction

endpackage

[rtl/ecal_in_if.sv]
// Input channel of the calendar block: valid/ready and the epoch count.
// No dependencies.
interface ecal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[rtl/ecal_out_if.sv]
// Output channel of the calendar block: valid/ready and the date fields.
// No dependencies.
interface ecal_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day_of_month,
                  output weekday, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input weekday, input hour, input minute, input second,
                  output ready);
endinterface

[rtl/ecal_alu.sv]
// Shared subtract-and-compare unit of the calendar block.
// Depends on ecal_pkg.
module ecal_alu (
  input  logic [ecal_pkg::REM_W-1:0] a_i,
  input  logic [ecal_pkg::REM_W-1:0] b_i,
  output ecal_pkg::alu_res_t         res_o
);
  import ecal_pkg::*;

  logic [REM_W:0] full;

  assign full       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~full[REM_W];
  assign res_o.diff = full[REM_W-1:0];

endmodule

[rtl/epoch_seconds_to_calendar_unit.sv]
// Top level: converts seconds since 1970-01-01 00:00:00 UTC to a calendar date.
// Depends on ecal_pkg, ecal_in_if, ecal_out_if and ecal_alu.

// One item at a time: after an epoch count is accepted, a sequencer drives one
// shared 32-bit subtract-and-compare unit. It strips whole years, then whole
// months, then splits the rest by restoring division into days (5 steps),
// hours (5) and minutes (6); what is left is the second. Weekday is carried
// mod 7 alongside. The finished date waits until the output register is free.
// The input is not ready while a conversion runs and comes back in the same
// cycle as the registered result. The result sits in an output register, so a
// new item is taken while the previous result still waits for its consumer.
module epoch_seconds_to_calendar_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecal_in_if.sink    in_i,
  ecal_out_if.source out_o
);
  import ecal_pkg::*;

  state_e           state_q, state_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [11:0]      year_q, year_d;
  logic [3:0]       month_q, month_d;
  logic [4:0]       day_q, day_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       minute_q, minute_d;
  logic [2:0]       wday_q, wday_d;
  logic [1:0]       mod4_q, mod4_d;
  logic [6:0]       mod100_q, mod100_d;
  logic [8:0]       mod400_q, mod400_d;
  logic [2:0]       step_q, step_d;

  logic             out_valid_q, out_valid_d;
  logic [11:0]      o_year_q, o_year_d;
  logic [3:0]       o_month_q, o_month_d;
  logic [4:0]       o_day_q, o_day_d;
  logic [2:0]       o_wday_q, o_wday_d;
  logic [4:0]       o_hour_q, o_hour_d;
  logic [5:0]       o_minute_q, o_minute_d;
  logic [5:0]       o_second_q, o_second_d;

  logic             leap;
  logic [REM_W-1:0] alu_b;
  alu_res_t         alu_res;
  logic [4:0]       day_full;

  // Gregorian rule from the running residues of the year.
  assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

  // Pick the subtrahend for the shared unit.
  always_comb begin
    case (state_q)
      ST_YEAR:  alu_b = leap ? YEAR_LEAP_SECS : YEAR_COMMON_SECS;
      ST_MONTH: alu_b = month_secs(month_q, leap);
      ST_DAY:   alu_b = SECS_PER_DAY << step_q;
      ST_HOUR:  alu_b = SECS_PER_HOUR << step_q;
      ST_MIN:   alu_b = SECS_PER_MINUTE << step_q;
      default:  alu_b = '0;
    endcase
  end

  ecal_alu u_alu (
    .a_i   (rem_q),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign day_full = {day_q[3:0], alu_res.ge};

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    wday_d     = wday_q;
    mod4_d     = mod4_q;
    mod100_d   = mod100_q;
    mod400_d   = mod400_q;
    step_d     = step_q;

    out_valid_d = out_valid_q;
    o_year_d    = o_year_q;
    o_month_d   = o_month_q;
    o_day_d     = o_day_q;
    o_wday_d    = o_wday_q;
    o_hour_d    = o_hour_q;
    o_minute_d  = o_minute_q;
    o_second_d  = o_second_q;

    // Drop the held result once the consumer takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rem_d    = in_i.epoch_seconds;
          year_d   = EPOCH_YEAR;
          wday_d   = EPOCH_WEEKDAY;
          mod4_d   = EPOCH_MOD4;
          mod100_d = EPOCH_MOD100;
          mod400_d = EPOCH_MOD400;
          state_d  = ST_YEAR;
        end
      end
      ST_YEAR: begin
        // Strip one whole year, or move on to months.
        if (alu_res.ge) begin
          rem_d    = alu_res.diff;
          year_d   = year_q + 12'd1;
          wday_d   = add_mod7(wday_q, leap ? 3'd2 : 3'd1);
          mod4_d   = mod4_q + 2'd1;
          mod100_d = (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
        end else begin
          month_d = 4'd1;
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        // Strip one whole month; December always stops.
        if (alu_res.ge && (month_q < LAST_MONTH)) begin
          rem_d   = alu_res.diff;
          month_d = month_q + 4'd1;
          wday_d  = add_mod7(wday_q, mod7_5(month_days(month_q, leap)));
        end else begin
          day_d   = '0;
          step_d  = 3'd4;
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        day_d = day_full;
        if (alu_res.ge) rem_d = alu_res.diff;
        if (step_q == 3'd0) begin
          wday_d  = add_mod7(wday_q, mod7_5(day_full));
          hour_d  = '0;
          step_d  = 3'd4;
          state_d = ST_HOUR;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_HOUR: begin
        hour_d = {hour_q[3:0], alu_res.ge};
        if (alu_res.ge) rem_d = alu_res.diff;
        if (step_q == 3'd0) begin
          minute_d = '0;
          step_d   = 3'd5;
          state_d  = ST_MIN;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_MIN: begin
        minute_d = {minute_q[4:0], alu_res.ge};
        if (alu_res.ge) rem_d = alu_res.diff;
        if (step_q == 3'd0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_DONE: begin
        // Hand the date to the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_year_d    = year_q;
          o_month_d   = month_q;
          o_day_d     = day_q + 5'd1;
          o_wday_d    = wday_q;
          o_hour_d    = hour_q;
          o_minute_d  = minute_q;
          o_second_d  = rem_q[5:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    year_q     <= year_d;
    month_q    <= month_d;
    day_q      <= day_d;
    hour_q     <= hour_d;
    minute_q   <= minute_d;
    wday_q     <= wday_d;
    mod4_q     <= mod4_d;
    mod100_q   <= mod100_d;
    mod400_q   <= mod400_d;
    step_q     <= step_d;
    o_year_q   <= o_year_d;
    o_month_q  <= o_month_d;
    o_day_q    <= o_day_d;
    o_wday_q   <= o_wday_d;
    o_hour_q   <= o_hour_d;
    o_minute_q <= o_minute_d;
    o_second_q <= o_second_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.year         = o_year_q;
  assign out_o.month        = o_month_q;
  assign out_o.day_of_month = o_day_q;
  assign out_o.weekday      = o_wday_q;
  assign out_o.hour         = o_hour_q;
  assign out_o.minute       = o_minute_q;
  assign out_o.second       = o_second_q;

endmodule

[rtl/ecal_chk.sv]
// Port-level checks for the calendar block, and the bind that attaches them.
// Depends on epoch_seconds_to_calendar_unit and its interfaces.
module ecal_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] year_i,
  input logic [3:0]  month_i,
  input logic [4:0]  day_of_month_i,
  input logic [2:0]  weekday_i,
  input logic [4:0]  hour_i,
  input logic [5:0]  minute_i,
  input logic [5:0]  second_i
);

  // Hold a stalled result and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(year_i) && $stable(month_i)
      && $stable(day_of_month_i) && $stable(weekday_i) && $stable(hour_i)
      && $stable(minute_i) && $stable(second_i))
    else $error("stalled result changed");

  // The block is not ready in the cycle after taking an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after accept");

  // A new result appears only out of a running conversion.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while idle");

  // Every shown field stays within its calendar range (day of month: lower bound only).
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> year_i >= 12'd1970 && year_i <= 12'd2106
      && month_i >= 4'd1 && month_i <= 4'd12
      && day_of_month_i >= 5'd1 && weekday_i <= 3'd6 && hour_i <= 5'd23
      && minute_i <= 6'd59 && second_i <= 6'd59)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_unit ecal_chk u_ecal_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .year_i         (out_o.year),
  .month_i        (out_o.month),
  .day_of_month_i (out_o.day_of_month),
  .weekday_i      (out_o.weekday),
  .hour_i         (out_o.hour),
  .minute_i       (out_o.minute),
  .second_i       (out_o.second)
);
